/* hdl/nmeasfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmeasfp_pkg
// Shared types, codes and helpers of the NMEA sentence field parser.
// ----------------------------------------------------------------------------
package nmeasfp_pkg;

   // default number of captured characters per field
   localparam int FIELD_CHARS_DEFAULT = 10;

   // character codes
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] HEX_LETTER_OFFSET = 8'h37;
   localparam logic [4:0] DOT_VALUE   = 5'h10;

   // header length after the dollar
   localparam logic [2:0] HEADER_LEN = 3'd5;

   // saturation limit of the field and index counters
   localparam logic [3:0] COUNT_MAX = 4'd15;

   // reset values of the control registers
   localparam logic [7:0]  TYPE1_SIG_RESET  = 8'h56;
   localparam logic [7:0]  TYPE2_SIG_RESET  = 8'h52;
   localparam logic [15:0] TYPE1_MASK_RESET = 16'd766;
   localparam logic [15:0] TYPE2_MASK_RESET = 16'd130;

   // control register indexes
   typedef enum logic [1:0] {
      CSR_TYPE1_SIG  = 2'd0,
      CSR_TYPE2_SIG  = 2'd1,
      CSR_TYPE1_MASK = 2'd2,
      CSR_TYPE2_MASK = 2'd3
   } csr_index_type;

   // sentence kinds
   localparam logic [1:0] KIND_UNKNOWN = 2'd0;
   localparam logic [1:0] KIND_TYPE1   = 2'd1;
   localparam logic [1:0] KIND_TYPE2   = 2'd2;

   // parser phases, one-hot
   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_HEADER = 5'b00010,
      PH_BODY   = 5'b00100,
      PH_CK1    = 5'b01000,
      PH_CK2    = 5'b10000
   } phase_type;

   // control register set
   typedef struct packed {
      logic [7:0]  type1_signature;
      logic [7:0]  type2_signature;
      logic [15:0] type1_field_mask;
      logic [15:0] type2_field_mask;
   } cfg_type;

   // one result beat
   typedef struct packed {
      logic [1:0] sentence_kind;
      logic [3:0] field_number;
      logic [3:0] char_position;
      logic [4:0] digit_value;
      logic [7:0] field_char;
      logic       capture;
      logic       sentence_done;
      logic       checksum_ok;
   } rsp_type;

   // hex digit value of a byte, dot gives sixteen, anything else zero
   function automatic logic [4:0] digit_of(input logic [7:0] b);
      logic [7:0] diff;
      diff = 8'h00;
      if (b == CHAR_DOT) begin
         return DOT_VALUE;
      end
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         diff = b - CHAR_ZERO;
         return diff[4:0];
      end
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         diff = b - HEX_LETTER_OFFSET;
         return diff[4:0];
      end
      return 5'd0;
   endfunction

endpackage

/* hdl/nmea_sentence_field_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_field_parser
// Byte-stream NMEA sentence parser giving per-byte field position and flags.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one received byte per beat, req_tdata[7:0] = in_byte.
//   rsp_*  : one result beat per input byte, in order. tuser carries the
//            sentence kind, tlast marks the second checksum character.
//   csr_*  : control register writes (index 0..3), always ready; write only
//            while no byte is in flight.
// Path: a byte accepted into the input register has its result registered
//   in the result register once that stage is free, raising rsp_tvalid.
// Throughput: one byte per cycle while the result side is not stalled; the
//   state update between the input and result registers allows it.
// Stalls: with rsp_tready low the result holds; one more byte is taken
//   into the input register, then req_tready drops until the result goes.
// Reset: both stages empty, parser idle awaiting a dollar, control
//   registers back to their default signatures and masks.
// ----------------------------------------------------------------------------
module nmea_sentence_field_parser #(
   parameter int FIELD_CHARS = nmeasfp_pkg::FIELD_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] field_number, [7:4] char_position,
                                    // [12:8] digit_value, [20:13] field_char,
                                    // [21] capture, [22] checksum_ok, [23] zero
   output logic [1:0]  rsp_tuser,   // [1:0] sentence_kind
   output logic        rsp_tlast,   // sentence_done
   // control register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   nmeasfp_pkg::cfg_type cfg;
   nmeasfp_pkg::rsp_type result;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   nmeasfp_pkg::rsp_type out_ff;
   logic       advance;
   logic       req_beat;

   nmeasfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   nmeasfp_parse #(
      .FIELD_CHARS (FIELD_CHARS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // pipeline handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   // result beat packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.checksum_ok, out_ff.capture, out_ff.field_char,
                        out_ff.digit_value, out_ff.char_position, out_ff.field_number};
   assign rsp_tuser  = out_ff.sentence_kind;
   assign rsp_tlast  = out_ff.sentence_done;

endmodule

/* hdl/nmeasfp_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmeasfp_csr
// Control registers: sentence signatures and per-type field masks.
// ----------------------------------------------------------------------------
module nmeasfp_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   output nmeasfp_pkg::cfg_type cfg
);

   nmeasfp_pkg::cfg_type cfg_ff;
   nmeasfp_pkg::cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            nmeasfp_pkg::CSR_TYPE1_SIG:  cfg_in.type1_signature  = csr_data[7:0];
            nmeasfp_pkg::CSR_TYPE2_SIG:  cfg_in.type2_signature  = csr_data[7:0];
            nmeasfp_pkg::CSR_TYPE1_MASK: cfg_in.type1_field_mask = csr_data;
            nmeasfp_pkg::CSR_TYPE2_MASK: cfg_in.type2_field_mask = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.type1_signature  <= nmeasfp_pkg::TYPE1_SIG_RESET;
         cfg_ff.type2_signature  <= nmeasfp_pkg::TYPE2_SIG_RESET;
         cfg_ff.type1_field_mask <= nmeasfp_pkg::TYPE1_MASK_RESET;
         cfg_ff.type2_field_mask <= nmeasfp_pkg::TYPE2_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/nmeasfp_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmeasfp_parse
// Sentence state tracker: header classification, body counters, checksum.
// ----------------------------------------------------------------------------
module nmeasfp_parse #(
   parameter int FIELD_CHARS = nmeasfp_pkg::FIELD_CHARS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   input  nmeasfp_pkg::cfg_type cfg,
   output nmeasfp_pkg::rsp_type result
);

   nmeasfp_pkg::phase_type phase_ff, phase_in;
   logic [2:0] header_count_ff, header_count_in;
   logic [7:0] header_xor_ff, header_xor_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] running_xor_ff, running_xor_in;
   logic [3:0] comma_count_ff, comma_count_in;
   logic [3:0] index_ff, index_in;
   logic       hi_match_ff, hi_match_in;

   logic [4:0]  dv;
   logic [15:0] mask;
   logic        cap;
   logic        done;
   logic        ok;

   // next state and flags for the byte in hand
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      header_xor_in   = header_xor_ff;
      kind_in         = kind_ff;
      running_xor_in  = running_xor_ff;
      comma_count_in  = comma_count_ff;
      index_in        = index_ff;
      hi_match_in     = hi_match_ff;
      dv   = nmeasfp_pkg::digit_of(in_byte);
      mask = (kind_ff == nmeasfp_pkg::KIND_TYPE1) ? cfg.type1_field_mask
                                                  : cfg.type2_field_mask;
      cap  = 1'b0;
      done = 1'b0;
      ok   = 1'b0;

      if (in_byte == nmeasfp_pkg::CHAR_DOLLAR || in_byte == nmeasfp_pkg::CHAR_LF) begin
         // sentence start or abort clears everything
         header_count_in = 3'd0;
         header_xor_in   = 8'h00;
         kind_in         = nmeasfp_pkg::KIND_UNKNOWN;
         running_xor_in  = 8'h00;
         comma_count_in  = 4'd0;
         index_in        = 4'd0;
         hi_match_in     = 1'b0;
         phase_in = (in_byte == nmeasfp_pkg::CHAR_DOLLAR) ? nmeasfp_pkg::PH_HEADER
                                                          : nmeasfp_pkg::PH_IDLE;
      end else begin
         case (phase_ff)
            nmeasfp_pkg::PH_HEADER: begin
               header_xor_in   = header_xor_ff ^ in_byte;
               header_count_in = header_count_ff + 3'd1;
               if (header_count_in >= nmeasfp_pkg::HEADER_LEN) begin
                  kind_in = nmeasfp_pkg::KIND_UNKNOWN;
                  if (header_xor_in == cfg.type1_signature) begin
                     kind_in = nmeasfp_pkg::KIND_TYPE1;
                  end
                  if (header_xor_in == cfg.type2_signature) begin
                     kind_in = nmeasfp_pkg::KIND_TYPE2;
                  end
                  running_xor_in = header_xor_in;
                  phase_in = (kind_in != nmeasfp_pkg::KIND_UNKNOWN) ? nmeasfp_pkg::PH_BODY
                                                                    : nmeasfp_pkg::PH_IDLE;
               end
            end
            nmeasfp_pkg::PH_BODY: begin
               if (in_byte == nmeasfp_pkg::CHAR_STAR) begin
                  phase_in = nmeasfp_pkg::PH_CK1;
               end else begin
                  running_xor_in = running_xor_ff ^ in_byte;
                  if (in_byte == nmeasfp_pkg::CHAR_COMMA) begin
                     if (comma_count_ff < nmeasfp_pkg::COUNT_MAX) begin
                        comma_count_in = comma_count_ff + 4'd1;
                     end
                     index_in = 4'd0;
                  end else if (index_ff < nmeasfp_pkg::COUNT_MAX) begin
                     index_in = index_ff + 4'd1;
                  end
                  cap = (index_in != 4'd0) && (index_in <= 4'(FIELD_CHARS)) &&
                        mask[comma_count_in];
               end
            end
            nmeasfp_pkg::PH_CK1: begin
               hi_match_in = (dv == {1'b0, running_xor_ff[7:4]});
               phase_in    = nmeasfp_pkg::PH_CK2;
            end
            nmeasfp_pkg::PH_CK2: begin
               done     = 1'b1;
               ok       = hi_match_ff && (dv == {1'b0, running_xor_ff[3:0]});
               phase_in = nmeasfp_pkg::PH_IDLE;
            end
            default: begin
               phase_in = nmeasfp_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // state registers, advanced once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= nmeasfp_pkg::PH_IDLE;
         header_count_ff <= 3'd0;
         header_xor_ff   <= 8'h00;
         kind_ff         <= nmeasfp_pkg::KIND_UNKNOWN;
         running_xor_ff  <= 8'h00;
         comma_count_ff  <= 4'd0;
         index_ff        <= 4'd0;
         hi_match_ff     <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         header_xor_ff   <= header_xor_in;
         kind_ff         <= kind_in;
         running_xor_ff  <= running_xor_in;
         comma_count_ff  <= comma_count_in;
         index_ff        <= index_in;
         hi_match_ff     <= hi_match_in;
      end
   end

   // result beat reflects the state after this byte
   always_comb begin
      result.sentence_kind = kind_in;
      result.field_number  = comma_count_in;
      result.char_position = index_in;
      result.digit_value   = dv;
      result.field_char    = in_byte;
      result.capture       = cap;
      result.sentence_done = done;
      result.checksum_ok   = ok;
   end

endmodule

/* hdl/nmeasfp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmeasfp_checker
// Port-level checks of the NMEA sentence field parser, bound to the top.
// ----------------------------------------------------------------------------
module nmeasfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // no result beat straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // sentence end only on a typed sentence
   a_done_typed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser != 2'd0)
      else $error("sentence end without a type");

   // checksum pass only with sentence end
   a_ok_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[22] |-> rsp_tlast)
      else $error("checksum flag without sentence end");

   // capture only inside a field of a typed sentence
   a_capture_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |-> rsp_tuser != 2'd0 && rsp_tdata[7:4] != 4'd0 &&
      !rsp_tlast)
      else $error("capture outside a field");

endmodule

bind nmea_sentence_field_parser nmeasfp_checker u_nmeasfp_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NMEA sentence field parser. Byte streams made of
// well-formed sentences with random content, unknown headers, cut-off
// sentences and raw noise are fed through the request stream. Each accepted
// byte is run through a bench-side parser model, and the result stream is
// compared beat by beat against it. Several register settings are used,
// including the extremes, equal signatures and the reset values. Both sides
// stall in random bursts, and the result side holds off once for long enough
// to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
   import nmeasfp_pkg::*;

   localparam int FIELD_CHARS = FIELD_CHARS_DEFAULT;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_BYTES = 330;
   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   // how the two checksum characters of a generated sentence are written
   typedef enum int {
      CK_GOOD,
      CK_BAD_HIGH,
      CK_BAD_LOW,
      CK_LOWER,
      CK_DOT
   } ck_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [3:0] field_number, [7:4] char_position,
                                      // [12:8] digit_value, [20:13] field_char,
                                      // [21] capture, [22] checksum_ok
   logic [1:0]  rsp_tuser;            // [1:0] sentence_kind
   logic        rsp_tlast;            // sentence_done
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = CSR_TYPE1_SIG;
   logic [15:0] csr_data   = 16'h0000;

   // bench bookkeeping
   logic [7:0]  byte_q[$];     // bytes waiting to be offered
   logic [7:0]  frame_q[$];    // sentence being assembled
   rsp_type     result_q[$];   // predicted result beats, oldest first
   int unsigned bytes_queued = 0;
   int unsigned bytes_taken  = 0;
   int unsigned results_seen = 0;
   int unsigned fail_count   = 0;
   bit          gaps_on      = 1'b1;
   bit          long_hold_done = 1'b0;

   // parser model state
   cfg_type     cfg;
   phase_type   parse_ph;
   logic [2:0]  hdr_count;
   logic [7:0]  hdr_xor;
   logic [1:0]  kind;
   logic [7:0]  csum;
   logic [3:0]  field_idx;
   logic [3:0]  char_idx;
   logic        hi_ok;

   nmea_sentence_field_parser #(
      .FIELD_CHARS(FIELD_CHARS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // parser model
   // ------------------------------------------------------------------------

   // hex value of an ascii byte, dot maps to sixteen
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      v = 5'd0;
      if (b[7:4] == 4'h3 && b[3:0] <= 4'h9) begin
         v = {1'b0, b[3:0]};
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         v = {1'b0, b[3:0]} + 5'd9;
      end else if (b == CHAR_DOT) begin
         v = DOT_VALUE;
      end
      return v;
   endfunction

   function automatic void drop_sentence();
      hdr_count = 3'd0;
      hdr_xor   = 8'h00;
      kind      = KIND_UNKNOWN;
      csum      = 8'h00;
      field_idx = 4'd0;
      char_idx  = 4'd0;
      hi_ok     = 1'b0;
   endfunction

   function automatic void reset_model();
      cfg.type1_signature  = TYPE1_SIG_RESET;
      cfg.type2_signature  = TYPE2_SIG_RESET;
      cfg.type1_field_mask = TYPE1_MASK_RESET;
      cfg.type2_field_mask = TYPE2_MASK_RESET;
      parse_ph = PH_IDLE;
      drop_sentence();
   endfunction

   // advance the model by one byte and return the beat it should produce
   function automatic rsp_type parse_byte(input logic [7:0] b);
      rsp_type     r;
      logic [15:0] mask;
      r = '0;
      r.digit_value = hex_value(b);
      r.field_char  = b;
      if (b == CHAR_DOLLAR) begin
         drop_sentence();
         parse_ph = PH_HEADER;
      end else if (b == CHAR_LF) begin
         drop_sentence();
         parse_ph = PH_IDLE;
      end else begin
         case (parse_ph)
            PH_HEADER: begin
               hdr_xor   ^= b;
               hdr_count += 3'd1;
               if (hdr_count >= HEADER_LEN) begin
                  kind = KIND_UNKNOWN;
                  if (hdr_xor == cfg.type1_signature) kind = KIND_TYPE1;
                  // type 2 wins when both signatures match
                  if (hdr_xor == cfg.type2_signature) kind = KIND_TYPE2;
                  csum = hdr_xor;
                  if (kind != KIND_UNKNOWN) parse_ph = PH_BODY;
                  else parse_ph = PH_IDLE;
               end
            end
            PH_BODY: begin
               if (b == CHAR_STAR) begin
                  parse_ph = PH_CK1;
               end else begin
                  if (kind == KIND_TYPE1) mask = cfg.type1_field_mask;
                  else mask = cfg.type2_field_mask;
                  csum ^= b;
                  if (b == CHAR_COMMA) begin
                     if (field_idx != COUNT_MAX) field_idx += 4'd1;
                     char_idx = 4'd0;
                  end else if (char_idx != COUNT_MAX) begin
                     char_idx += 4'd1;
                  end
                  r.capture = (char_idx >= 4'd1 && char_idx <= FIELD_CHARS) &&
                              mask[field_idx];
               end
            end
            PH_CK1: begin
               hi_ok    = (r.digit_value == {1'b0, csum[7:4]});
               parse_ph = PH_CK2;
            end
            PH_CK2: begin
               r.sentence_done = 1'b1;
               r.checksum_ok   = hi_ok && (r.digit_value == {1'b0, csum[3:0]});
               parse_ph        = PH_IDLE;
            end
            default: begin
               parse_ph = PH_IDLE;
            end
         endcase
      end
      r.sentence_kind = kind;
      r.field_number  = field_idx;
      r.char_position = char_idx;
      return r;
   endfunction

   function automatic string show(input rsp_type r);
      return $sformatf("kind %0d field %0d pos %0d digit %0d char %02h cap %0b done %0b ok %0b",
                       r.sentence_kind, r.field_number, r.char_position, r.digit_value,
                       r.field_char, r.capture, r.sentence_done, r.checksum_ok);
   endfunction

   // ------------------------------------------------------------------------
   // byte stream generation
   // ------------------------------------------------------------------------

   function automatic void add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return CHAR_ZERO + {4'h0, n};
      if (lower) return 8'h61 + {4'h0, n} - 8'd10;
      return CHAR_UPPER_A + {4'h0, n} - 8'd10;
   endfunction

   // star plus two checksum characters over everything since the last dollar
   function automatic void close_sentence(input ck_mode_type mode);
      logic [7:0] x;
      logic [3:0] hi, lo;
      int         start, i;
      x = 8'h00;
      start = 0;
      foreach (frame_q[i]) if (frame_q[i] == CHAR_DOLLAR) start = i;
      for (i = start + 1; i < frame_q.size(); i++) x ^= frame_q[i];
      hi = x[7:4];
      lo = x[3:0];
      if (mode == CK_BAD_HIGH) hi ^= 4'($urandom_range(1, 15));
      if (mode == CK_BAD_LOW) lo ^= 4'($urandom_range(1, 15));
      frame_q.push_back(CHAR_STAR);
      if (mode == CK_DOT) frame_q.push_back(CHAR_DOT);
      else frame_q.push_back(hex_char(hi, mode == CK_LOWER));
      frame_q.push_back(hex_char(lo, mode == CK_LOWER));
   endfunction

   // body byte, never one that would end or restart the sentence
   function automatic logic [7:0] body_char();
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: b = CHAR_ZERO + 8'($urandom_range(0, 9));
         5:             b = CHAR_DOT;
         6:             b = CHAR_UPPER_A + 8'($urandom_range(0, 5));
         7:             b = 8'($urandom_range(8'h47, 8'h5A));
         default: begin
            do b = 8'($urandom);
            while (b == CHAR_DOLLAR || b == CHAR_LF || b == CHAR_STAR || b == CHAR_COMMA);
         end
      endcase
      return b;
   endfunction

   // full sentence whose five header bytes xor to the given value
   function automatic void add_sentence(input logic [7:0] target);
      logic [7:0]  hdr[5];
      logic [7:0]  x;
      int          c, f, n_fields, len;
      ck_mode_type mode;
      do begin
         x = target;
         for (c = 0; c < 4; c++) begin
            hdr[c] = 8'($urandom_range(8'h41, 8'h5A));
            x ^= hdr[c];
         end
      end while (x == CHAR_DOLLAR || x == CHAR_LF);
      hdr[4] = x;
      frame_q.push_back(CHAR_DOLLAR);
      for (c = 0; c < 5; c++) frame_q.push_back(hdr[c]);
      // mostly short sentences, now and then enough commas or characters to saturate
      if ($urandom_range(0, 9) == 0) n_fields = $urandom_range(9, 18);
      else n_fields = $urandom_range(0, 8);
      for (f = 0; f < n_fields; f++) begin
         frame_q.push_back(CHAR_COMMA);
         if ($urandom_range(0, 7) == 0) len = $urandom_range(9, 17);
         else len = $urandom_range(0, 6);
         for (c = 0; c < len; c++) frame_q.push_back(body_char());
      end
      mode = CK_GOOD;
      if ($urandom_range(0, 3) == 0) mode = ck_mode_type'($urandom_range(1, 4));
      close_sentence(mode);
      // trailing cr lf, a few idle bytes, or straight into the next dollar
      case ($urandom_range(0, 3))
         0, 1: begin
            frame_q.push_back(8'h0D);
            frame_q.push_back(CHAR_LF);
         end
         2: begin
            for (c = $urandom_range(1, 3); c > 0; c--) frame_q.push_back(body_char());
         end
         default: ;
      endcase
   endfunction

   function automatic void flush_frame();
      while (frame_q.size() > 0) begin
         byte_q.push_back(frame_q.pop_front());
         bytes_queued++;
      end
   endfunction

   // short fixed opening: byte extremes, a known position sentence, unknown header
   function automatic void directed_bytes();
      frame_q.push_back(8'h00);
      frame_q.push_back(8'hFF);
      frame_q.push_back(CHAR_LF);
      add_text("$GPGGA,A.9");
      close_sentence(CK_GOOD);
      add_text("$QQQQQ1");
      flush_frame();
   endfunction

   function automatic void random_traffic(input int unsigned budget);
      int unsigned stop_at, pick, c, cut;
      logic [7:0]  sig;
      stop_at = bytes_queued + budget;
      while (bytes_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 1) != 0) sig = cfg.type1_signature;
         else sig = cfg.type2_signature;
         if (pick < 70) begin
            add_sentence(sig);
         end else if (pick < 80) begin
            add_sentence(8'($urandom));
         end else if (pick < 90) begin
            // sentence broken off part way, then a line feed or a fresh dollar
            add_sentence(sig);
            cut = $urandom_range(2, frame_q.size() - 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
            if ($urandom_range(0, 1) != 0) frame_q.push_back(CHAR_LF);
         end else begin
            for (c = $urandom_range(1, 8); c > 0; c--) frame_q.push_back(8'($urandom));
         end
         flush_frame();
      end
   endfunction

   // ------------------------------------------------------------------------
   // register writes, only while the parser is empty
   // ------------------------------------------------------------------------

   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TYPE1_SIG:  cfg.type1_signature  = value[7:0];
         CSR_TYPE2_SIG:  cfg.type2_signature  = value[7:0];
         CSR_TYPE1_MASK: cfg.type1_field_mask = value;
         CSR_TYPE2_MASK: cfg.type2_field_mask = value;
         default: ;
      endcase
   endtask

   task automatic set_registers(input int n);
      logic [15:0] s1, s2, m1, m2;
      case (n)
         1: begin
            // signature extremes, upper data bits set to show they are dropped
            s1 = 16'hA500;
            s2 = 16'h5AFF;
            m1 = 16'hFFFF;
            m2 = 16'h0000;
         end
         2: begin
            // equal signatures
            s1 = 16'($urandom);
            s2 = {8'($urandom), s1[7:0]};
            m1 = 16'h0000;
            m2 = 16'hFFFF;
         end
         NUM_PHASES - 1: begin
            s1 = {8'h00, TYPE1_SIG_RESET};
            s2 = {8'h00, TYPE2_SIG_RESET};
            m1 = TYPE1_MASK_RESET;
            m2 = TYPE2_MASK_RESET;
         end
         default: begin
            s1 = 16'($urandom);
            s2 = 16'($urandom);
            m1 = 16'($urandom);
            m2 = 16'($urandom);
         end
      endcase
      @(posedge clock);
      write_register(CSR_TYPE1_SIG, s1);
      write_register(CSR_TYPE2_SIG, s2);
      write_register(CSR_TYPE1_MASK, m1);
      write_register(CSR_TYPE2_MASK, m2);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (bytes_taken != bytes_queued || result_q.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // byte driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : byte_driver
      int unsigned gap_left = 0;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         // accepted beat: predict its result
         if (req_tvalid && req_tready) begin
            result_q.push_back(parse_byte(req_tdata));
            bytes_taken++;
         end
         // next beat, unless the current one is still waiting
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (gaps_on && byte_q.size() > 0 && $urandom_range(0, 9) == 0) begin
               gap_left = $urandom_range(0, 18);
               req_tvalid <= 1'b0;
            end else if (byte_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= byte_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      int unsigned hold_left = 0;
      rsp_type     got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.sentence_kind = rsp_tuser;
            got.field_number  = rsp_tdata[3:0];
            got.char_position = rsp_tdata[7:4];
            got.digit_value   = rsp_tdata[12:8];
            got.field_char    = rsp_tdata[20:13];
            got.capture       = rsp_tdata[21];
            got.checksum_ok   = rsp_tdata[22];
            got.sentence_done = rsp_tlast;
            results_seen++;
            if (result_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("beat %0d arrived with nothing predicted: %s",
                           results_seen, show(got));
            end else begin
               want = result_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("beat %0d mismatch\n  expected %s\n  actual   %s",
                              results_seen, show(want), show(got));
               end
            end
         end
         // ready: random bursts low, one long hold-off while bytes keep coming
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && results_seen >= 500 && byte_q.size() > 40) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 11) == 0) begin
            hold_left = $urandom_range(0, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog on cycles without any beat
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      int unsigned quiet_cycles = 0;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // run sequence
   // ------------------------------------------------------------------------
   initial begin : run_sequence
      int phase_no;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (phase_no = 0; phase_no < NUM_PHASES; phase_no++) begin
         if (phase_no > 0) set_registers(phase_no);
         // the closing stretch runs without stalls
         gaps_on = (phase_no != NUM_PHASES - 1);
         if (phase_no == 0) directed_bytes();
         random_traffic(PHASE_BYTES);
         wait_drained();
      end
      repeat (4) @(posedge clock);
      fail_count += result_q.size();
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
